[rtl/mkte_pkg.sv]
// Shared types, codes and letter-group tables for the multi-tap keypad
// text entry unit. No dependencies.
`default_nettype none

package mkte_pkg;

  localparam int BUF_CHARS  = 32;
  localparam int LOCK_CHARS = 16;
  localparam int ADDR_W     = $clog2(BUF_CHARS);
  localparam int LEN_W      = $clog2(BUF_CHARS + 1);
  localparam int CHAR_W     = 8;
  localparam int TIME_W     = 32;
  localparam int TMO_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [TMO_W-1:0] TMO_RESET = TMO_W'(800);

  // Item modes
  localparam logic [1:0] MODE_KEY   = 2'd0;
  localparam logic [1:0] MODE_CLEAR = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  // Key codes
  localparam logic [3:0] KEY_DOT   = 4'd10;
  localparam logic [3:0] KEY_DEL   = 4'd11;
  localparam logic [3:0] KEY_SHIFT = 4'd12;
  localparam logic [3:0] KEY_NONE  = 4'd13;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_REJECT   = 2'd1;
  localparam logic [1:0] ST_DISABLED = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCK    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd2;

  localparam logic [CHAR_W-1:0] CH_DOT  = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;

  typedef struct packed {
    logic [1:0]        mode;
    logic [3:0]        key_code;
    logic [TIME_W-1:0] time_ms;
    logic [ADDR_W-1:0] read_position;
  } in_item_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CHAR_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [LEN_W-1:0]  text_length;
    logic              char_written;
    logic [ADDR_W-1:0] write_position;
    logic [CHAR_W-1:0] write_char;
    logic              read_hit;
  } res_t;

  // Number of letters on a key; zero for keys without letters
  function automatic logic [3:0] grp_len(input logic [3:0] key);
    logic [3:0] n;
    case (key)
      4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd8: n = 4'd6;
      4'd7, 4'd9:                         n = 4'd8;
      default:                            n = 4'd0;
    endcase
    return n;
  endfunction

  // Letter at position idx of a key's group: lowercase first, then uppercase
  function automatic logic [CHAR_W-1:0] grp_char(input logic [3:0] key,
                                                 input logic [2:0] idx);
    logic [CHAR_W-1:0] base;
    logic [2:0]        half;
    logic [2:0]        ofs;
    logic [CHAR_W-1:0] c;
    base = 8'h00;
    half = 3'd3;
    case (key)
      4'd2: base = 8'h61;
      4'd3: base = 8'h64;
      4'd4: base = 8'h67;
      4'd5: base = 8'h6A;
      4'd6: base = 8'h6D;
      4'd7: begin
        base = 8'h70;
        half = 3'd4;
      end
      4'd8: base = 8'h74;
      4'd9: begin
        base = 8'h77;
        half = 3'd4;
      end
      default: base = 8'h00;
    endcase
    if (base == 8'h00 || {1'b0, idx} >= grp_len(key)) begin
      c = 8'h00;
    end else if (idx < half) begin
      c = base + {5'b0, idx};
    end else begin
      ofs = idx - half;
      c = base - 8'h20 + {5'b0, ofs};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/mkte_in_if.sv]
// Key item channel: valid/ready handshake with the item fields.
// Depends on mkte_pkg.
`default_nettype none

interface mkte_in_if;
  import mkte_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        mode;
  logic [3:0]        key_code;
  logic [TIME_W-1:0] time_ms;
  logic [ADDR_W-1:0] read_position;

  modport source (output valid, mode, key_code, time_ms, read_position, input ready);
  modport sink   (input valid, mode, key_code, time_ms, read_position, output ready);
endinterface

`default_nettype wire

[rtl/mkte_out_if.sv]
// Result channel: valid/ready handshake with the result fields.
// Depends on mkte_pkg.
`default_nettype none

interface mkte_out_if;
  import mkte_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [LEN_W-1:0]  text_length;
  logic              char_written;
  logic [ADDR_W-1:0] write_position;
  logic [CHAR_W-1:0] write_char;
  logic [CHAR_W-1:0] read_char;

  modport source (output valid, status, text_length, char_written, write_position,
                  write_char, read_char, input ready);
  modport sink   (input valid, status, text_length, char_written, write_position,
                  write_char, read_char, output ready);
endinterface

`default_nettype wire

[rtl/mkte_cfg_if.sv]
// Configuration write channel: valid/ready, register index and write data.
// Depends on mkte_pkg.
`default_nettype none

interface mkte_cfg_if;
  import mkte_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  idx;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, idx, data, input ready);
  modport sink   (input valid, idx, data, output ready);
endinterface

`default_nettype wire

[rtl/mkte_text_mem.sv]
// Text buffer RAM: one write and one registered read per cycle.
// Depends on mkte_pkg.
`default_nettype none

module mkte_text_mem (
  input  wire logic                      clk,
  input  wire mkte_pkg::mem_req_t        req,
  output logic [mkte_pkg::CHAR_W-1:0]    rdata
);
  import mkte_pkg::*;

  logic [CHAR_W-1:0] mem [BUF_CHARS];
  logic [CHAR_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Hold read data until the next read so a stalled result keeps its value
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[rtl/mkte_edit_ctrl.sv]
// Editor control: configuration and cursor/mode state, per-item decode,
// buffer write and read requests. Depends on mkte_pkg.
`default_nettype none

module mkte_edit_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          item_acc,
  input  wire mkte_pkg::in_item_t            item,
  input  wire logic                          cfg_we,
  input  wire logic [mkte_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [mkte_pkg::CFG_DATA_W-1:0] cfg_data,
  output mkte_pkg::mem_req_t                 mem_req,
  output mkte_pkg::res_t                     res
);
  import mkte_pkg::*;

  logic              enabled_r;
  logic              locked_r;
  logic [TMO_W-1:0]  timeout_r;

  logic [LEN_W-1:0]  len_r,      len_nxt;
  logic              letter_r,   letter_nxt;
  logic [2:0]        gidx_r,     gidx_nxt;
  logic [3:0]        pkey_r,     pkey_nxt;
  logic [TIME_W-1:0] ptime_r,    ptime_nxt;
  logic              seen_r,     seen_nxt;

  logic [LEN_W-1:0]  limit;
  logic [TIME_W-1:0] dt;
  logic              rpt;
  logic [2:0]        idx;
  logic [CHAR_W-1:0] letter;
  logic              do_app;
  logic              do_rep;
  logic [CHAR_W-1:0] new_char;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r <= 1'b1;
      locked_r  <= 1'b0;
      timeout_r <= TMO_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_ENABLE:  enabled_r <= cfg_data[0];
        CFG_LOCK:    locked_r  <= cfg_data[0];
        CFG_TIMEOUT: timeout_r <= cfg_data[TMO_W-1:0];
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r    <= '0;
      letter_r <= 1'b0;
      gidx_r   <= '0;
      pkey_r   <= KEY_NONE;
      ptime_r  <= '0;
      seen_r   <= 1'b0;
    end else if (item_acc) begin
      len_r    <= len_nxt;
      letter_r <= letter_nxt;
      gidx_r   <= gidx_nxt;
      pkey_r   <= pkey_nxt;
      ptime_r  <= ptime_nxt;
      seen_r   <= seen_nxt;
    end
  end

  assign limit = (locked_r && LOCK_CHARS < BUF_CHARS) ? LEN_W'(LOCK_CHARS)
                                                      : LEN_W'(BUF_CHARS);

  // Multi-tap letter pick
  assign dt     = item.time_ms - ptime_r;
  assign rpt    = seen_r && (item.key_code == pkey_r) && (dt < {16'b0, timeout_r});
  assign idx    = (!rpt || {1'b0, gidx_r} >= grp_len(item.key_code)) ? 3'd0 : gidx_r;
  assign letter = grp_char(item.key_code, idx);

  always_comb begin
    len_nxt    = len_r;
    letter_nxt = letter_r;
    gidx_nxt   = gidx_r;
    pkey_nxt   = pkey_r;
    ptime_nxt  = ptime_r;
    seen_nxt   = seen_r;
    do_app     = 1'b0;
    do_rep     = 1'b0;
    new_char   = '0;
    mem_req    = '0;
    res        = '0;
    res.status = ST_OK;

    unique case (item.mode)
      MODE_CLEAR: len_nxt = '0;
      MODE_READ: begin
        mem_req.re    = item_acc;
        mem_req.raddr = item.read_position;
        res.read_hit  = {1'b0, item.read_position} < len_r;
      end
      MODE_KEY: begin
        if (!enabled_r) begin
          res.status = ST_DISABLED;
        end else if (item.key_code == KEY_SHIFT) begin
          if (!locked_r) begin
            letter_nxt = ~letter_r;
          end
          res.status = ST_REJECT;
        end else if (item.key_code > KEY_SHIFT) begin
          res.status = ST_REJECT;
        end else begin
          if (item.key_code == KEY_DEL) begin
            if (len_r != '0) begin
              len_nxt = len_r - LEN_W'(1);
            end
          end else if (item.key_code == KEY_DOT) begin
            do_app   = 1'b1;
            new_char = CH_DOT;
          end else begin
            pkey_nxt  = item.key_code;
            ptime_nxt = item.time_ms;
            seen_nxt  = 1'b1;
            if (!letter_r) begin
              do_app   = 1'b1;
              new_char = CH_ZERO + {4'b0, item.key_code};
            end else begin
              gidx_nxt = idx + 3'd1;
              new_char = letter;
              if (letter != '0) begin
                // Repeat on an empty buffer appends instead
                do_rep = rpt && (len_r != '0);
                do_app = !(rpt && (len_r != '0));
              end
            end
          end

          if (do_app && len_r < limit) begin
            res.char_written   = 1'b1;
            res.write_position = len_r[ADDR_W-1:0];
            len_nxt            = len_r + LEN_W'(1);
          end else if (do_rep && len_r <= limit) begin
            res.char_written   = 1'b1;
            res.write_position = ADDR_W'(len_r - LEN_W'(1));
          end
          if (res.char_written) begin
            res.write_char = new_char;
          end
          if (len_nxt > limit) begin
            len_nxt = limit;
          end
        end
      end
      default: res.status = ST_REJECT;
    endcase

    res.text_length = len_nxt;
    mem_req.we      = item_acc && res.char_written;
    mem_req.waddr   = res.write_position;
    mem_req.wdata   = res.write_char;
  end

endmodule

`default_nettype wire

[rtl/multitap_keypad_text_entry_unit.sv]
// Top level of the multi-tap keypad text entry unit: item, result and
// configuration channels, output register. Depends on mkte_pkg, the three
// channel interfaces, mkte_edit_ctrl and mkte_text_mem.
`default_nettype none

// Phone-style multi-tap text editor. Each transaction on in_ch is a key
// press, a buffer clear or a character read, and yields exactly one result
// transaction on out_ch. Throughput is one transaction per clock while out_ch
// is ready; the result appears in the cycle after acceptance. All editor state
// except the text itself lives in flip-flops and is updated in the accept
// cycle; the 32 x 8 text buffer is a synchronous RAM written in that same
// cycle and read through a registered output, in step with the result
// register. A read is accepted only after any earlier write is stored, so no
// forwarding is needed. in_ch.ready stays high while the result register is
// empty or is being drained, so a new item enters in the same cycle the
// previous result leaves. Configuration writes (cfg_ch, always ready) are
// expected only while no result is pending; the text buffer comes out of reset
// with undefined contents, but reads at or above the current length give zero.
module multitap_keypad_text_entry_unit (
  input  wire logic  clk,
  input  wire logic  rst_n,
  mkte_in_if.sink    in_ch,
  mkte_out_if.source out_ch,
  mkte_cfg_if.sink   cfg_ch
);
  import mkte_pkg::*;

  in_item_t          item;
  logic              item_acc;
  mem_req_t          mem_req;
  res_t              res;
  res_t              res_r;
  logic              out_valid_r;
  logic [CHAR_W-1:0] mem_rdata;

  // Accept whenever the result register is free or is drained this cycle
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign item_acc    = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign item.mode          = in_ch.mode;
  assign item.key_code      = in_ch.key_code;
  assign item.time_ms       = in_ch.time_ms;
  assign item.read_position = in_ch.read_position;

  mkte_edit_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .item_acc (item_acc),
    .item     (item),
    .cfg_we   (cfg_ch.valid),
    .cfg_idx  (cfg_ch.idx),
    .cfg_data (cfg_ch.data),
    .mem_req  (mem_req),
    .res      (res)
  );

  mkte_text_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  // Output register: load on accept, drop valid once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (item_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_acc) begin
      res_r <= res;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = res_r.status;
  assign out_ch.text_length    = res_r.text_length;
  assign out_ch.char_written   = res_r.char_written;
  assign out_ch.write_position = res_r.write_position;
  assign out_ch.write_char     = res_r.write_char;
  // RAM read data holds until the next read, so it stays valid while stalled
  assign out_ch.read_char      = res_r.read_hit ? mem_rdata : '0;

endmodule

`default_nettype wire
